[rtl/tcf_pkg.sv]
// Shared types, constants and tables for the tilt complementary filter.
// Used by tcf_ctrl, tcf_datapath and tilt_complementary_filter; no dependencies.
`default_nettype none

package tcf_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int GAIN_W     = 17;
    localparam int ANGLE_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CORD_W     = 36;
    localparam int IDX_W      = 5;
    localparam int STEP_W     = 4;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;

    localparam logic [GAIN_W-1:0] DECAY_RESET = 17'd655;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 17'd655;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_DECAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_GAIN   = 2'd1;

    // Input item kinds.
    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    localparam logic signed [ANGLE_W-1:0] PI_Q28 = 32'sd843314857;

    // Last multiply-accumulate step of the smoothing part and of the whole program.
    localparam logic [STEP_W-1:0] MAC_LAST_SMOOTH = 4'd7;
    localparam logic [STEP_W-1:0] MAC_LAST        = 4'd11;
    localparam logic [STEP_W-1:0] MAC_BLEND_FIRST = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SQRT,
        ST_CR_LOAD,
        ST_CR_RUN,
        ST_CP_LOAD,
        ST_CP_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_DECAY_X,
        OP_DECAY_Y,
        OP_DECAY_Z,
        OP_SAMPLE_X,
        OP_SAMPLE_Y,
        OP_SAMPLE_Z,
        OP_SQ_X,
        OP_SQ_Z,
        OP_KEEP_P,
        OP_NEW_P,
        OP_KEEP_R,
        OP_NEW_R
    } op_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ZERO,
        ACC_HALF
    } acc_init_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_SX,
        DST_SY,
        DST_SZ,
        DST_R2,
        DST_PITCH,
        DST_ROLL
    } dst_t;

    typedef struct packed {
        op_sel_t   sel;
        acc_init_t init;
        logic      shift;
        dst_t      dst;
    } mac_op_t;

    typedef struct packed {
        logic             capture;
        logic             predict;
        logic             mul_en;
        logic             acc_en;
        mac_op_t          mac;
        logic             sq_step;
        logic             cr_load;
        logic             cr_src;
        logic             cr_step;
        logic             save_roll;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    // MAC program: each step pair is a weighted mix or a sum of two squares.
    function automatic mac_op_t mac_prog(input logic [STEP_W-1:0] step);
        mac_op_t op;
        begin
            op = '{sel: OP_DECAY_X, init: ACC_HOLD, shift: 1'b0, dst: DST_NONE};
            case (step)
                4'd0:  op = '{sel: OP_DECAY_X,  init: ACC_HALF, shift: 1'b0, dst: DST_NONE};
                4'd1:  op = '{sel: OP_SAMPLE_X, init: ACC_HOLD, shift: 1'b1, dst: DST_SX};
                4'd2:  op = '{sel: OP_DECAY_Y,  init: ACC_HALF, shift: 1'b0, dst: DST_NONE};
                4'd3:  op = '{sel: OP_SAMPLE_Y, init: ACC_HOLD, shift: 1'b1, dst: DST_SY};
                4'd4:  op = '{sel: OP_DECAY_Z,  init: ACC_HALF, shift: 1'b0, dst: DST_NONE};
                4'd5:  op = '{sel: OP_SAMPLE_Z, init: ACC_HOLD, shift: 1'b1, dst: DST_SZ};
                4'd6:  op = '{sel: OP_SQ_X,     init: ACC_ZERO, shift: 1'b0, dst: DST_NONE};
                4'd7:  op = '{sel: OP_SQ_Z,     init: ACC_HOLD, shift: 1'b0, dst: DST_R2};
                4'd8:  op = '{sel: OP_KEEP_P,   init: ACC_HALF, shift: 1'b0, dst: DST_NONE};
                4'd9:  op = '{sel: OP_NEW_P,    init: ACC_HOLD, shift: 1'b0, dst: DST_PITCH};
                4'd10: op = '{sel: OP_KEEP_R,   init: ACC_HALF, shift: 1'b0, dst: DST_NONE};
                4'd11: op = '{sel: OP_NEW_R,    init: ACC_HOLD, shift: 1'b0, dst: DST_ROLL};
                default: op = '{sel: OP_DECAY_X, init: ACC_HOLD, shift: 1'b0, dst: DST_NONE};
            endcase
            return op;
        end
    endfunction

    // atan(2^-i) in Q3.28, rounded to nearest.
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
        logic signed [ANGLE_W-1:0] v;
        begin
            case (i)
                5'd0:  v = 32'sd210828714;
                5'd1:  v = 32'sd124459457;
                5'd2:  v = 32'sd65760959;
                5'd3:  v = 32'sd33381290;
                5'd4:  v = 32'sd16755422;
                5'd5:  v = 32'sd8385879;
                5'd6:  v = 32'sd4193963;
                5'd7:  v = 32'sd2097109;
                5'd8:  v = 32'sd1048571;
                5'd9:  v = 32'sd524287;
                5'd10: v = 32'sd262144;
                5'd11: v = 32'sd131072;
                5'd12: v = 32'sd65536;
                5'd13: v = 32'sd32768;
                5'd14: v = 32'sd16384;
                5'd15: v = 32'sd8192;
                5'd16: v = 32'sd4096;
                5'd17: v = 32'sd2048;
                5'd18: v = 32'sd1024;
                5'd19: v = 32'sd512;
                5'd20: v = 32'sd256;
                5'd21: v = 32'sd128;
                5'd22: v = 32'sd64;
                5'd23: v = 32'sd32;
                5'd24: v = 32'sd16;
                5'd25: v = 32'sd8;
                5'd26: v = 32'sd4;
                5'd27: v = 32'sd2;
                5'd28: v = 32'sd1;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        begin
            if (v > 66'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -66'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[ANGLE_W-1:0];
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/tilt_complementary_filter.sv]
// Top level of the tilt complementary filter: joins tcf_ctrl and tcf_datapath.
// Depends on tcf_pkg.
//
// Usage: input items arrive on the s_ channel. s_tuser selects the kind of item:
// a predict item adds the gyro increments in s_tdata to the kept pitch and roll,
// an update item smooths the accelerometer samples and blends the angles found by
// CORDIC vectoring into the kept pitch and roll. Each item gives one result item
// on the m_ channel holding the angles after that step.
// The cfg_ channel writes smooth_decay (index 0) and blend_gain (index 1); it is
// always ready, and writes to other indexes are dropped. Write it only while idle.
// An update item runs twelve steps of the one shared multiplier, 32 square-root
// steps, and two CORDIC runs on one shared unit.
// Items are worked on one at a time; the next one is accepted once the result
// has moved to the output register, so a waiting result does not block the input.
// If the receiver stalls with a result already waiting, the finished item holds
// in the controller until the output register frees up.
// Reset clears the kept angles and smoothed samples to zero and sets both gains to
// 655 (about 0.01); no result is pending after reset.
`default_nettype none

module tilt_complementary_filter
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // pitch_delta[31:0], roll_delta[63:32], accel_x[79:64], accel_y[95:80],
    // accel_z[111:96]
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // command[0]
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pitch[31:0], roll[63:32]
    output logic      [OUT_DATA_W-1:0]  m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [GAIN_W-1:0]      cfg_data
);

    dp_cmd_t cmd;

    // Configuration writes complete at once.
    assign cfg_ready = 1'b1;

    tcf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tcf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/tcf_datapath.sv]
// Datapath of the tilt complementary filter: kept state, shared multiplier and
// accumulator, bit-serial square root and CORDIC vectoring unit. Uses tcf_pkg.
`default_nettype none

module tcf_datapath
    import tcf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_cmd_t                cmd,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [GAIN_W-1:0]      cfg_data,
    output logic      [OUT_DATA_W-1:0]  m_tdata
);

    logic [GAIN_W-1:0]                decay_reg;
    logic [GAIN_W-1:0]                gain_reg;
    logic signed [SAMPLE_W-1:0]       ax_reg, ay_reg, az_reg;
    logic signed [ANGLE_W-1:0]        pitch_reg, roll_reg;
    logic signed [ANGLE_W-1:0]        sx_reg, sy_reg, sz_reg;
    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [PROD_W-1:0]         acc_reg;
    logic [63:0]                      sq_rem_reg, sq_res_reg;
    logic signed [CORD_W-1:0]         cx_reg, cy_reg;
    logic signed [ANGLE_W-1:0]        cz_reg;
    logic                             hold_reg;
    logic signed [ANGLE_W-1:0]        roll_ang_reg;
    logic [OUT_DATA_W-1:0]            out_data_reg;

    logic signed [ANGLE_W-1:0]        pitch_delta, roll_delta;
    logic signed [ANGLE_W-1:0]        pitch_pred, roll_pred;
    logic signed [17:0]               one_minus_d, one_minus_g;
    logic signed [MUL_W-1:0]          mul_a, mul_b;
    logic signed [PROD_W-1:0]         acc_base, acc_next;
    logic signed [ANGLE_W-1:0]        acc_sat;
    logic [5:0]                       sq_shamt;
    logic [63:0]                      sq_bit, sq_trial;
    logic signed [CORD_W-1:0]         cy0, cx0, cdx, cdy;
    logic                             cy_pos;

    assign pitch_delta = s_tdata[31:0];
    assign roll_delta  = s_tdata[63:32];
    assign pitch_pred  = sat32(PROD_W'(pitch_reg) + PROD_W'(pitch_delta));
    assign roll_pred   = sat32(PROD_W'(roll_reg) + PROD_W'(roll_delta));

    assign one_minus_d = 18'sh10000 - $signed({1'b0, decay_reg});
    assign one_minus_g = 18'sh10000 - $signed({1'b0, gain_reg});

    always_comb
    begin
        mul_a = MUL_W'(one_minus_d);
        mul_b = MUL_W'(sx_reg);
        case (cmd.mac.sel)
            OP_DECAY_X:
            begin
                mul_a = MUL_W'(one_minus_d);
                mul_b = MUL_W'(sx_reg);
            end
            OP_DECAY_Y:
            begin
                mul_a = MUL_W'(one_minus_d);
                mul_b = MUL_W'(sy_reg);
            end
            OP_DECAY_Z:
            begin
                mul_a = MUL_W'(one_minus_d);
                mul_b = MUL_W'(sz_reg);
            end
            OP_SAMPLE_X:
            begin
                mul_a = $signed({16'd0, decay_reg});
                mul_b = MUL_W'(ax_reg);
            end
            OP_SAMPLE_Y:
            begin
                mul_a = $signed({16'd0, decay_reg});
                mul_b = MUL_W'(ay_reg);
            end
            OP_SAMPLE_Z:
            begin
                mul_a = $signed({16'd0, decay_reg});
                mul_b = MUL_W'(az_reg);
            end
            OP_SQ_X:
            begin
                mul_a = MUL_W'(sx_reg);
                mul_b = MUL_W'(sx_reg);
            end
            OP_SQ_Z:
            begin
                mul_a = MUL_W'(sz_reg);
                mul_b = MUL_W'(sz_reg);
            end
            OP_KEEP_P:
            begin
                mul_a = MUL_W'(one_minus_g);
                mul_b = MUL_W'(pitch_reg);
            end
            OP_NEW_P:
            begin
                mul_a = $signed({16'd0, gain_reg});
                mul_b = MUL_W'(cz_reg);
            end
            OP_KEEP_R:
            begin
                mul_a = MUL_W'(one_minus_g);
                mul_b = MUL_W'(roll_reg);
            end
            OP_NEW_R:
            begin
                mul_a = $signed({16'd0, gain_reg});
                mul_b = MUL_W'(roll_ang_reg);
            end
            default:
            begin
                mul_a = MUL_W'(one_minus_d);
                mul_b = MUL_W'(sx_reg);
            end
        endcase
    end

    always_comb
    begin
        case (cmd.mac.init)
            ACC_ZERO: acc_base = '0;
            ACC_HALF: acc_base = 66'sd32768;
            default:  acc_base = acc_reg;
        endcase
    end

    // A sample scaled by 2^16 contributes its product shifted up by 16.
    assign acc_next = acc_base + (cmd.mac.shift ? (prod_reg <<< 16) : prod_reg);
    assign acc_sat  = sat32(acc_next >>> 16);

    // Square root: one result bit per step, largest bit first.
    assign sq_shamt = 6'd62 - {cmd.idx, 1'b0};
    assign sq_bit   = 64'd1 << sq_shamt;
    assign sq_trial = sq_res_reg + sq_bit;

    // CORDIC vectoring sources: roll from (sx, sz), pitch from (-sy, sqrt).
    assign cy0    = cmd.cr_src ? -CORD_W'(sy_reg) : CORD_W'(sx_reg);
    assign cx0    = cmd.cr_src ? $signed({4'd0, sq_res_reg[31:0]}) : CORD_W'(sz_reg);
    assign cdx    = cy_reg >>> cmd.idx;
    assign cdy    = cx_reg >>> cmd.idx;
    assign cy_pos = !cy_reg[CORD_W-1] && (cy_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
            gain_reg  <= GAIN_RESET;
            pitch_reg <= '0;
            roll_reg  <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sz_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_SMOOTH_DECAY)
                decay_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_BLEND_GAIN)
                gain_reg <= cfg_data;
            if (cmd.predict)
            begin
                pitch_reg <= pitch_pred;
                roll_reg  <= roll_pred;
            end
            if (cmd.acc_en)
            begin
                case (cmd.mac.dst)
                    DST_SX:    sx_reg    <= acc_sat;
                    DST_SY:    sy_reg    <= acc_sat;
                    DST_SZ:    sz_reg    <= acc_sat;
                    DST_PITCH: pitch_reg <= acc_sat;
                    DST_ROLL:  roll_reg  <= acc_sat;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ax_reg <= s_tdata[79:64];
            ay_reg <= s_tdata[95:80];
            az_reg <= s_tdata[111:96];
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
            if (cmd.mac.dst == DST_R2)
            begin
                sq_rem_reg <= acc_next[63:0];
                sq_res_reg <= '0;
            end
        end
        if (cmd.sq_step)
        begin
            if (sq_rem_reg >= sq_trial)
            begin
                sq_rem_reg <= sq_rem_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit;
            end
            else
                sq_res_reg <= sq_res_reg >> 1;
        end
        if (cmd.save_roll)
            roll_ang_reg <= cz_reg;
        if (cmd.cr_load)
        begin
            if (cy0 == '0)
            begin
                hold_reg <= 1'b1;
                cx_reg   <= cx0;
                cy_reg   <= cy0;
                cz_reg   <= cx0[CORD_W-1] ? PI_Q28 : '0;
            end
            else if (cx0[CORD_W-1])
            begin
                hold_reg <= 1'b0;
                cx_reg   <= -cx0;
                cy_reg   <= -cy0;
                cz_reg   <= cy0[CORD_W-1] ? -PI_Q28 : PI_Q28;
            end
            else
            begin
                hold_reg <= 1'b0;
                cx_reg   <= cx0;
                cy_reg   <= cy0;
                cz_reg   <= '0;
            end
        end
        else if (cmd.cr_step && !hold_reg)
        begin
            if (cy_pos)
            begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + atan_entry(cmd.idx);
            end
            else
            begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - atan_entry(cmd.idx);
            end
        end
        if (cmd.out_load)
            out_data_reg <= {roll_reg, pitch_reg};
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

[rtl/tcf_ctrl.sv]
// Controller of the tilt complementary filter: sequences the multiply program,
// square root and both CORDIC runs, and owns the handshakes. Uses tcf_pkg.
`default_nettype none

module tcf_ctrl
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire logic    s_tuser,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd
);

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CORDIC_STEPS - 1);
    localparam logic [IDX_W-1:0] SQ_LAST   = '1;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    step_next  = '0;
                    state_next = (s_tuser == CMD_UPDATE) ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (step_reg == MAC_LAST_SMOOTH)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else if (step_reg == MAC_LAST)
                    state_next = ST_DONE;
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQ_LAST)
                    state_next = ST_CR_LOAD;
            end
            ST_CR_LOAD:
            begin
                cnt_next   = '0;
                state_next = ST_CR_RUN;
            end
            ST_CR_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = ST_CP_LOAD;
            end
            ST_CP_LOAD:
            begin
                cnt_next   = '0;
                state_next = ST_CP_RUN;
            end
            ST_CP_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    step_next  = MAC_BLEND_FIRST;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mac       = mac_prog(step_reg);
        cmd.idx       = cnt_reg;
        cmd.capture   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.predict   = (state_reg == ST_IDLE) && s_tvalid && (s_tuser == CMD_PREDICT);
        cmd.mul_en    = (state_reg == ST_MUL);
        cmd.acc_en    = (state_reg == ST_ACC);
        cmd.sq_step   = (state_reg == ST_SQRT);
        cmd.cr_load   = (state_reg == ST_CR_LOAD) || (state_reg == ST_CP_LOAD);
        cmd.cr_src    = (state_reg == ST_CP_LOAD);
        cmd.cr_step   = (state_reg == ST_CR_RUN) || (state_reg == ST_CP_RUN);
        cmd.save_roll = (state_reg == ST_CP_LOAD);
        cmd.out_load  = (state_reg == ST_DONE) && out_free;
        s_tready      = (state_reg == ST_IDLE);
        m_tvalid      = out_valid_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE))
        else $error("finished item left DONE while the output was still full");

    a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> ($past(state_reg) == ST_MUL))
        else $error("accumulate step not preceded by its multiply");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (step_reg <= MAC_LAST))
        else $error("multiply program step out of range");

    a_roll_to_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CR_RUN && cnt_reg == LAST_STEP) |=> (state_reg == ST_CP_LOAD))
        else $error("roll CORDIC run did not hand over to the pitch run");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for tilt_complementary_filter: drives predict and update
// items with random handshake gaps and checks every result against a local model.
// Depends on tcf_pkg and the tilt_complementary_filter RTL.
`timescale 1ns / 1ps

module testbench;
    import tcf_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam longint PI_FIX = 843314857;

    typedef struct {
        logic                cmd;
        logic signed [31:0]  d_pitch;
        logic signed [31:0]  d_roll;
        logic signed [15:0]  ax;
        logic signed [15:0]  ay;
        logic signed [15:0]  az;
    } imu_item_t;

    typedef struct {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
    } angles_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    // Queue of items waiting for the driver, and queue of predicted angles.
    imu_item_t pending_items[$];
    angles_t   angles_due[$];

    // Predictor state.
    longint decay_w, blend_w;
    longint est_pitch, est_roll;
    longint avg_x, avg_y, avg_z;

    int errors;
    int n_update, n_predict, n_results;
    int burst_left, gap_left;
    int stall_phase;
    bit sender_hold;
    bit in_fire;

    tilt_complementary_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Weighted mix with round-half-up; >>> on longint is a floor shift.
    function automatic longint blend(input longint w, input longint old_v,
                                     input longint new_v);
        longint acc;
        acc = (65536 - w) * old_v + w * new_v + 32768;
        return clamp32(acc >>> 16);
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
                res = res >> 1;
            bit_v = bit_v >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint arctan_step(input int i);
        longint tab [0:31];
        tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
                16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4,
                2, 1, 0, 0, 0};
        return tab[i];
    endfunction

    // CORDIC vectoring angle of (x, y), pre-rotated by pi for negative x.
    function automatic longint vector_angle(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        if (y == 0)
            return (x < 0) ? PI_FIX : 0;
        if (x < 0)
        begin
            z = (y > 0) ? PI_FIX : -PI_FIX;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step(i);
            end
        end
        return z;
    endfunction

    // Advances the kept angles by one item and returns them.
    function automatic angles_t track_tilt(input imu_item_t it);
        angles_t a;
        longint roll_acc, pitch_acc, r2;
        if (it.cmd == CMD_PREDICT)
        begin
            est_pitch = clamp32(est_pitch + longint'(it.d_pitch));
            est_roll  = clamp32(est_roll + longint'(it.d_roll));
        end
        else
        begin
            avg_x = blend(decay_w, avg_x, longint'(it.ax) * 65536);
            avg_y = blend(decay_w, avg_y, longint'(it.ay) * 65536);
            avg_z = blend(decay_w, avg_z, longint'(it.az) * 65536);
            roll_acc = vector_angle(avg_x, avg_z);
            r2 = avg_x * avg_x + avg_z * avg_z;
            pitch_acc = vector_angle(-avg_y, int_sqrt(r2));
            est_pitch = blend(blend_w, est_pitch, pitch_acc);
            est_roll  = blend(blend_w, est_roll, roll_acc);
        end
        a.pitch = est_pitch[31:0];
        a.roll  = est_roll[31:0];
        return a;
    endfunction

    // Remembers whether the item on the input was taken at the last rising edge.
    always @(posedge clk)
    begin
        in_fire <= s_tvalid && s_tready;
    end

    // Driver: bursts of items separated by random gaps, changed on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_fire)
            begin
                // Hold the current item until it is taken.
            end
            else if (gap_left > 0 || sender_hold)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                imu_item_t it;
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.cmd;
                s_tdata  <= {it.az, it.ay, it.ax, it.d_roll, it.d_pitch};
                angles_due.push_back(track_tilt(it));
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver stall pattern: long stretches of ready and stretches of random stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[10])
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) < 60);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            angles_t exp_a;
            n_results <= n_results + 1;
            if (angles_due.size() == 0)
            begin
                $display("%0t: unexpected result pitch=%0d roll=%0d", $time,
                         $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                errors = errors + 1;
            end
            else
            begin
                exp_a = angles_due.pop_front();
                if (m_tdata[31:0] !== exp_a.pitch)
                begin
                    $display("%0t: pitch mismatch expected %0d actual %0d", $time,
                             exp_a.pitch, $signed(m_tdata[31:0]));
                    errors = errors + 1;
                end
                if (m_tdata[63:32] !== exp_a.roll)
                begin
                    $display("%0t: roll mismatch expected %0d actual %0d", $time,
                             exp_a.roll, $signed(m_tdata[63:32]));
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic add_item(input logic cmd, input logic signed [31:0] dp,
                            input logic signed [31:0] dr, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
        imu_item_t it;
        it = '{cmd, dp, dr, x, y, z};
        pending_items.push_back(it);
        if (cmd == CMD_UPDATE)
            n_update++;
        else
            n_predict++;
    endtask

    task automatic add_random_items(input int count);
        logic signed [15:0] bx, by, bz;
        bx = 16'($urandom);
        by = 16'($urandom);
        bz = 16'($urandom);
        for (int i = 0; i < count; i++)
        begin
            // Mostly updates jittering around a random base vector, with some full-range noise.
            if ($urandom_range(0, 2) == 0)
                add_item(CMD_PREDICT, ($urandom_range(0, 3) == 0) ? $urandom
                         : $signed($urandom_range(0, 2000000)) - 1000000,
                         ($urandom_range(0, 3) == 0) ? $urandom
                         : $signed($urandom_range(0, 2000000)) - 1000000,
                         16'($urandom), 16'($urandom), 16'($urandom));
            else if ($urandom_range(0, 4) == 0)
                add_item(CMD_UPDATE, $urandom, $urandom, 16'($urandom), 16'($urandom),
                         16'($urandom));
            else
                add_item(CMD_UPDATE, $urandom, $urandom,
                         16'(bx + $signed($urandom_range(0, 200)) - 100),
                         16'(by + $signed($urandom_range(0, 200)) - 100),
                         16'(bz + $signed($urandom_range(0, 200)) - 100));
        end
    endtask

    // Waits until all items are taken and all results are in, then lets the block settle.
    task automatic drain;
        while (pending_items.size() > 0 || angles_due.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_SMOOTH_DECAY)
            decay_w = val;
        else if (idx == CFG_BLEND_GAIN)
            blend_w = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        n_update = 0;
        n_predict = 0;
        n_results = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        sender_hold = 1'b0;
        in_fire = 1'b0;
        decay_w = 655;
        blend_w = 655;
        est_pitch = 0;
        est_roll = 0;
        avg_x = 0;
        avg_y = 0;
        avg_z = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero vector, extremes, negative x with zero y, delta saturation.
        add_item(CMD_UPDATE, 0, 0, 0, 0, 0);
        add_item(CMD_PREDICT, 32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 16'sh8000, 0);
        add_item(CMD_PREDICT, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0);
        add_item(CMD_PREDICT, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0);
        add_item(CMD_PREDICT, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0);
        add_item(CMD_UPDATE, 32'sh7FFFFFFF, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_item(CMD_UPDATE, 0, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_item(CMD_UPDATE, 0, 0, 0, 0, 16'sh8000);
        add_item(CMD_UPDATE, 0, 0, 16'sh8000, 0, 16'sh7FFF);
        add_item(CMD_UPDATE, 0, 0, 0, 16'sh7FFF, 0);
        drain();

        // Full decay and full gain: angles follow the accelerometer directly.
        write_reg(CFG_SMOOTH_DECAY, 17'd65536);
        write_reg(CFG_BLEND_GAIN, 17'd65536);
        add_item(CMD_UPDATE, 0, 0, 0, 0, 16'sh8000);
        add_item(CMD_UPDATE, 0, 0, 0, 0, 16'sh8000);
        add_item(CMD_UPDATE, 0, 0, 16'sh8000, 16'sh7FFF, 16'sh8000);
        add_item(CMD_UPDATE, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh0001);
        add_item(CMD_UPDATE, 0, 0, 0, 0, 0);
        add_random_items(150);
        drain();

        // Extrapolating settings above 1.0 drive the kept values into saturation.
        write_reg(CFG_SMOOTH_DECAY, 17'h1FFFF);
        write_reg(CFG_BLEND_GAIN, 17'h1FFFF);
        write_reg(2'd3, 17'd5);
        add_random_items(150);
        drain();

        // Zero weights: the smoothed samples and the blend hold still.
        write_reg(CFG_SMOOTH_DECAY, 17'd0);
        write_reg(CFG_BLEND_GAIN, 17'd0);
        add_random_items(100);
        drain();

        // Random settings for the bulk of the run; one phase holds the sender back
        // with items queued, then releases it.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_SMOOTH_DECAY, 17'($urandom_range(0, 65536)));
            write_reg(CFG_BLEND_GAIN, 17'($urandom_range(0, 65536)));
            if (ph == 2)
            begin
                sender_hold = 1'b1;
                add_random_items(10);
                repeat (300) @(posedge clk);
                sender_hold = 1'b0;
            end
            add_random_items(150);
            drain();
        end
        write_reg(CFG_SMOOTH_DECAY, 17'd655);
        write_reg(CFG_BLEND_GAIN, 17'd655);
        add_random_items(50);
        drain();

        $display("Covered %0d predict and %0d update items, %0d results checked,",
                 n_predict, n_update, n_results);
        $display("under default, unity, zero, maximum and random gain settings.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog well above the slowest correct run.
    initial
    begin
        #5000000;
        $display("Timeout waiting for results.");
        $display("TEST FAILED");
        $finish;
    end

endmodule
